// ===== rtl/atl_pkg.sv =====
// ----------------------------------------------------------------------------
// Arithmetic token lexer package
// Transaction types, character classes, DFA states, token kinds and the
// move and kind tables shared by the lexer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package atl_pkg;

   // Input transaction: one character plus its end-of-line mark.
   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_line;
   } req_type;

   // Result transaction: one token.
   typedef struct packed {
      logic [3:0] token_kind;
      logic [7:0] token_length;
      logic       last_in_run;
   } rsp_type;

   // Everything one character produces: one or two tokens.
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } bundle_type;

   // Queue status seen by the front end and the back end.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam int QUEUE_DEPTH = 2;

   // Hard limit of the token length field.
   localparam int LENGTH_FIELD_MAX = 255;

   typedef enum logic [3:0] {
      CL_DIGIT,
      CL_DOT,
      CL_E,
      CL_MINUS,
      CL_OP,
      CL_SPACE,
      CL_SLASH,
      CL_ALPHA,
      CL_UNDER,
      CL_OTHER
   } char_class_type;

   typedef enum logic [10:0] {
      S_START = 11'b000_0000_0001,
      S_INT   = 11'b000_0000_0010,
      S_DOT   = 11'b000_0000_0100,
      S_E     = 11'b000_0000_1000,
      S_ESIGN = 11'b000_0001_0000,
      S_ID    = 11'b000_0010_0000,
      S_OP    = 11'b000_0100_0000,
      S_DIV   = 11'b000_1000_0000,
      S_COM   = 11'b001_0000_0000,
      S_FRAC  = 11'b010_0000_0000,
      S_EXP   = 11'b100_0000_0000
   } dfa_state_type;

   typedef struct packed {
      logic          ok;
      dfa_state_type next_state;
   } move_type;

   localparam logic [3:0] KIND_INTEGER    = 4'd0;
   localparam logic [3:0] KIND_FLOAT      = 4'd1;
   localparam logic [3:0] KIND_EXPONENT   = 4'd2;
   localparam logic [3:0] KIND_IDENTIFIER = 4'd3;
   localparam logic [3:0] KIND_OPERATOR   = 4'd4;
   localparam logic [3:0] KIND_DIVISION   = 4'd5;
   localparam logic [3:0] KIND_COMMENT    = 4'd6;
   localparam logic [3:0] KIND_INCOMPLETE = 4'd7;
   localparam logic [3:0] KIND_INVALID    = 4'd8;

   function automatic char_class_type char_class(input logic [7:0] c);
      char_class_type cls;
      if (c inside {["0":"9"]}) begin
         cls = CL_DIGIT;
      end else if (c == ".") begin
         cls = CL_DOT;
      end else if (c inside {"e", "E"}) begin
         cls = CL_E;
      end else if (c == "-") begin
         cls = CL_MINUS;
      end else if (c inside {"+", "*", "=", "^", "(", ")"}) begin
         cls = CL_OP;
      end else if (c == " ") begin
         cls = CL_SPACE;
      end else if (c == "/") begin
         cls = CL_SLASH;
      end else if (c inside {["a":"z"], ["A":"Z"]}) begin
         cls = CL_ALPHA;
      end else if (c == "_") begin
         cls = CL_UNDER;
      end else begin
         cls = CL_OTHER;
      end
      return cls;
   endfunction

   function automatic move_type dfa_move(input dfa_state_type st,
                                         input char_class_type cls);
      move_type mv;
      mv.ok         = 1'b1;
      mv.next_state = S_START;
      case (st)
         S_START: begin
            case (cls)
               CL_DIGIT:          mv.next_state = S_INT;
               CL_E, CL_ALPHA:    mv.next_state = S_ID;
               CL_MINUS, CL_OP:   mv.next_state = S_OP;
               CL_SPACE:          mv.next_state = S_START;
               CL_SLASH:          mv.next_state = S_DIV;
               default:           mv.ok = 1'b0;
            endcase
         end
         S_INT: begin
            case (cls)
               CL_DIGIT: mv.next_state = S_INT;
               CL_DOT:   mv.next_state = S_DOT;
               CL_E:     mv.next_state = S_E;
               default:  mv.ok = 1'b0;
            endcase
         end
         S_DOT: begin
            case (cls)
               CL_DIGIT: mv.next_state = S_FRAC;
               default:  mv.ok = 1'b0;
            endcase
         end
         S_E: begin
            case (cls)
               CL_DIGIT: mv.next_state = S_EXP;
               CL_MINUS: mv.next_state = S_ESIGN;
               default:  mv.ok = 1'b0;
            endcase
         end
         S_ESIGN, S_EXP: begin
            case (cls)
               CL_DIGIT: mv.next_state = S_EXP;
               default:  mv.ok = 1'b0;
            endcase
         end
         S_ID: begin
            // A letter e or E ends an identifier.
            case (cls)
               CL_DIGIT, CL_ALPHA, CL_UNDER: mv.next_state = S_ID;
               default:                      mv.ok = 1'b0;
            endcase
         end
         S_DIV: begin
            case (cls)
               CL_SLASH: mv.next_state = S_COM;
               default:  mv.ok = 1'b0;
            endcase
         end
         S_COM: begin
            mv.next_state = S_COM;
         end
         S_FRAC: begin
            case (cls)
               CL_DIGIT: mv.next_state = S_FRAC;
               CL_E:     mv.next_state = S_E;
               default:  mv.ok = 1'b0;
            endcase
         end
         default: begin
            // The operator state and any unused code reject everything.
            mv.ok = 1'b0;
         end
      endcase
      return mv;
   endfunction

   function automatic logic [3:0] dfa_kind(input dfa_state_type st);
      logic [3:0] kind;
      case (st)
         S_INT:   kind = KIND_INTEGER;
         S_FRAC:  kind = KIND_FLOAT;
         S_EXP:   kind = KIND_EXPONENT;
         S_ID:    kind = KIND_IDENTIFIER;
         S_OP:    kind = KIND_OPERATOR;
         S_DIV:   kind = KIND_DIVISION;
         S_COM:   kind = KIND_COMMENT;
         default: kind = KIND_INCOMPLETE;
      endcase
      return kind;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/atl_front.sv =====
// ----------------------------------------------------------------------------
// Arithmetic token lexer front end
// Classifies each accepted character, steps the DFA and packs the tokens
// that the character closes into one bundle for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module atl_front
   import atl_pkg::*;
#(
   parameter int TOKEN_LENGTH_MAX = 255
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire req_type          req_data,
   output logic                  push,
   output bundle_type            push_data
);

   localparam int CAP = (TOKEN_LENGTH_MAX > LENGTH_FIELD_MAX) ?
                        LENGTH_FIELD_MAX : TOKEN_LENGTH_MAX;
   localparam logic [7:0] LENGTH_CAP = 8'(CAP);

   dfa_state_type  state_ff, state_in;
   logic [7:0]     count_ff, count_in;

   char_class_type cls;
   move_type       mv;
   move_type       mv_start;
   rsp_type        tok_a, tok_b;
   logic           has_a, has_b;

   always_comb begin
      cls      = char_class(req_data.char_byte);
      mv       = dfa_move(state_ff, cls);
      mv_start = dfa_move(S_START, cls);
      state_in = state_ff;
      count_in = count_ff;
      has_a    = 1'b0;
      has_b    = 1'b0;
      tok_a    = '{token_kind: KIND_INVALID, token_length: 8'd1, last_in_run: 1'b0};
      tok_b    = '{token_kind: KIND_INVALID, token_length: 8'd1, last_in_run: 1'b1};

      if (state_ff == S_START) begin
         if (!mv.ok) begin
            has_a = 1'b1;
         end else if (mv.next_state != S_START) begin
            state_in = mv.next_state;
            count_in = 8'd1;
         end
      end else if (mv.ok) begin
         state_in = mv.next_state;
         if (count_ff < LENGTH_CAP) begin
            count_in = count_ff + 8'd1;
         end
      end else begin
         // The open token ends here; the character is retried from start.
         has_a              = 1'b1;
         tok_a.token_kind   = dfa_kind(state_ff);
         tok_a.token_length = count_ff;
         state_in           = S_START;
         count_in           = 8'd0;
         if (!mv_start.ok) begin
            has_b = 1'b1;
         end else if (mv_start.next_state != S_START) begin
            state_in = mv_start.next_state;
            count_in = 8'd1;
         end
      end

      if (req_data.end_of_line && (state_in != S_START)) begin
         if (has_a) begin
            has_b              = 1'b1;
            tok_b.token_kind   = dfa_kind(state_in);
            tok_b.token_length = count_in;
         end else begin
            has_a              = 1'b1;
            tok_a.token_kind   = dfa_kind(state_in);
            tok_a.token_length = count_in;
         end
         state_in = S_START;
         count_in = 8'd0;
      end

      tok_a.last_in_run = !has_b;
      push              = fire && has_a;
      push_data         = '{two: has_b, first: tok_a, second: tok_b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_START;
         count_ff <= 8'd0;
      end else if (fire) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/atl_queue.sv =====
// ----------------------------------------------------------------------------
// Arithmetic token lexer queue
// Short register queue of token bundles between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module atl_queue
   import atl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire bundle_type    push_data,
   input  wire logic          pop,
   output bundle_type         head,
   output queue_status_type   status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   bundle_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == FULL_CNT);
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      head         = entry_ff[rd_ptr_ff];
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/atl_back.sv =====
// ----------------------------------------------------------------------------
// Arithmetic token lexer back end
// Takes token bundles from the queue and delivers their tokens one at a
// time through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module atl_back
   import atl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bundle_type        head,
   input  wire queue_status_type  status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic    pend_ff, pend_in;
   rsp_type pend_data_ff, pend_data_in;
   logic    load;

   always_comb begin
      load         = !valid_ff || !rsp_stall;
      valid_in     = valid_ff;
      data_in      = data_ff;
      pend_in      = pend_ff;
      pend_data_in = pend_data_ff;
      pop          = 1'b0;
      if (load) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            data_in  = pend_data_ff;
            pend_in  = 1'b0;
         end else if (!status.empty) begin
            pop          = 1'b1;
            valid_in     = 1'b1;
            data_in      = head.first;
            pend_in      = head.two;
            pend_data_in = head.second;
         end else begin
            valid_in = 1'b0;
         end
      end
      rsp_valid = valid_ff;
      rsp_data  = data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff      <= data_in;
      pend_data_ff <= pend_data_in;
   end

endmodule

`default_nettype wire

// ===== rtl/arithmetic_token_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// Arithmetic token lexer
// Splits a character stream into number, identifier, operator, division and
// comment tokens, reporting each token's kind and length.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Ports                          Transaction
//   req      in         req_valid, req_stall, req_data one character
//   rsp      out        rsp_valid, rsp_stall, rsp_data one token
//
// The block takes one character per cycle while the queue has room. The
// DFA state update in the front end is the loop that sets this rate. A
// token passes through a queue entry and the output register. A character
// that closes two tokens holds the back end for both, so a run of them
// drains at one token per cycle unless the output stalls, and stalls the
// input once the two-entry queue fills. Synchronous reset returns the DFA
// to S_START with no open token and empties the queue and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module arithmetic_token_lexer_unit
   import atl_pkg::*;
#(
   parameter int TOKEN_LENGTH_MAX = 255
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req_data,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   // Front end: a character transaction is taken whenever the queue has
   // room, independent of whether the output register is being drained.
   logic             fire;
   logic             push;
   bundle_type       push_data;
   bundle_type       head;
   logic             pop;
   queue_status_type status;

   assign req_stall = status.full;
   assign fire      = req_valid && !req_stall;

   atl_front #(
      .TOKEN_LENGTH_MAX (TOKEN_LENGTH_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data)
   );

   // The queue holds whole bundles, so a character that produces no token
   // never takes a slot.
   atl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (status)
   );

   // Back end: one token per result transaction, with the second token of
   // a bundle held aside until the first has been taken.
   atl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/tb_arithmetic_token_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// Arithmetic token lexer testbench
// Streams directed and random character lines into the lexer with random
// gaps and output stalls, predicts every token from its own DFA and checks
// each result transaction, field by field, in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_arithmetic_token_lexer_unit
   import atl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOKEN_LIMIT = 255;
   // The length field cannot count past 255 whatever the parameter says.
   localparam int LENGTH_CAP  = (TOKEN_LIMIT > LENGTH_FIELD_MAX) ? LENGTH_FIELD_MAX
                                                                 : TOKEN_LIMIT;
   localparam int RANDOM_CHARS = 430;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 10;

   // One character waiting to be sent, with the idle cycles that come
   // before it and a flag that holds it back until all tokens are out.
   typedef struct {
      req_type data;
      int      gap;
      bit      drain_first;
   } char_slot_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   char_slot_type pending_chars[$];
   rsp_type       expected_tokens[$];
   rsp_type       step_tokens[$];
   logic [7:0]    line_buf[$];

   // Predictor state: the open token's DFA state and its length so far.
   dfa_state_type lex_state = S_START;
   logic [7:0]    lex_len   = '0;

   int  error_count = 0;
   int  cycle_count = 0;
   int  idle_left   = 0;
   int  stall_left  = 0;
   int  send_calm   = 0;
   int  recv_calm   = 0;
   bit  drain_next  = 1'b0;

   arithmetic_token_lexer_unit #(
      .TOKEN_LENGTH_MAX (TOKEN_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Token predictor
   // ------------------------------------------------------------------------

   function automatic char_class_type sort_char(input logic [7:0] c);
      if (c >= "0" && c <= "9")                      return CL_DIGIT;
      if (c == ".")                                  return CL_DOT;
      if (c == "e" || c == "E")                      return CL_E;
      if (c == "-")                                  return CL_MINUS;
      if (c inside {"+", "*", "=", "^", "(", ")"})   return CL_OP;
      if (c == " ")                                  return CL_SPACE;
      if (c == "/")                                  return CL_SLASH;
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CL_ALPHA;
      if (c == "_")                                  return CL_UNDER;
      return CL_OTHER;
   endfunction

   // Returns 1 when the state has a move on this class and gives the target.
   function automatic bit lex_move(input dfa_state_type st, input char_class_type cls,
                                   output dfa_state_type target);
      target = S_START;
      if (st == S_START) begin
         if (cls == CL_DIGIT) target = S_INT;
         else if (cls == CL_E || cls == CL_ALPHA) target = S_ID;
         else if (cls == CL_MINUS || cls == CL_OP) target = S_OP;
         else if (cls == CL_SLASH) target = S_DIV;
         else if (cls != CL_SPACE) return 1'b0;
         return 1'b1;
      end
      if (st == S_COM) begin
         // A comment swallows everything up to the end of its line.
         target = S_COM;
         return 1'b1;
      end
      if (cls == CL_DIGIT) begin
         case (st)
            S_INT:          target = S_INT;
            S_DOT, S_FRAC:  target = S_FRAC;
            S_E, S_ESIGN,
            S_EXP:          target = S_EXP;
            S_ID:           target = S_ID;
            default:        return 1'b0;
         endcase
         return 1'b1;
      end
      if (st == S_INT && cls == CL_DOT) target = S_DOT;
      else if ((st == S_INT || st == S_FRAC) && cls == CL_E) target = S_E;
      else if (st == S_E && cls == CL_MINUS) target = S_ESIGN;
      else if (st == S_ID && (cls == CL_ALPHA || cls == CL_UNDER)) target = S_ID;
      else if (st == S_DIV && cls == CL_SLASH) target = S_COM;
      else return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [3:0] token_kind_of(input dfa_state_type st);
      case (st)
         S_INT:   return KIND_INTEGER;
         S_FRAC:  return KIND_FLOAT;
         S_EXP:   return KIND_EXPONENT;
         S_ID:    return KIND_IDENTIFIER;
         S_OP:    return KIND_OPERATOR;
         S_DIV:   return KIND_DIVISION;
         S_COM:   return KIND_COMMENT;
         default: return KIND_INCOMPLETE;
      endcase
   endfunction

   task automatic emit_token(input logic [3:0] kind, input logic [7:0] len);
      rsp_type tok;
      tok.token_kind   = kind;
      tok.token_length = len;
      tok.last_in_run  = 1'b0;
      step_tokens.push_back(tok);
   endtask

   // Opens a token from the start state, or reports the character as
   // invalid when the start state has no move for it.
   task automatic open_token(input char_class_type cls);
      dfa_state_type target;
      if (!lex_move(S_START, cls, target)) begin
         emit_token(KIND_INVALID, 8'd1);
      end else if (target != S_START) begin
         lex_state = target;
         lex_len   = 8'd1;
      end
   endtask

   // Steps the predictor on one accepted character and queues its tokens.
   task automatic predict_tokens(input req_type item);
      char_class_type cls;
      dfa_state_type  target;
      cls = sort_char(item.char_byte);
      step_tokens.delete();
      if (lex_state == S_START) begin
         open_token(cls);
      end else if (lex_move(lex_state, cls, target)) begin
         lex_state = target;
         if (lex_len < LENGTH_CAP) lex_len++;
      end else begin
         // The open token ends here and the character starts over.
         emit_token(token_kind_of(lex_state), lex_len);
         lex_state = S_START;
         lex_len   = '0;
         open_token(cls);
      end
      if (item.end_of_line && lex_state != S_START) begin
         emit_token(token_kind_of(lex_state), lex_len);
         lex_state = S_START;
         lex_len   = '0;
      end
      if (step_tokens.size() != 0) begin
         step_tokens[step_tokens.size() - 1].last_in_run = 1'b1;
      end
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Mostly no idle time, sometimes a short gap, now and then a long pause.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 62) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // Moves the line buffer into the send queue; end of line on the last one when eol is set.
   task automatic send_line(input bit eol);
      char_slot_type slot;
      foreach (line_buf[i]) begin
         slot.data.char_byte   = line_buf[i];
         slot.data.end_of_line = eol && (i == line_buf.size() - 1);
         slot.drain_first      = (i == 0) && drain_next;
         if (send_calm > 0) begin
            send_calm--;
            slot.gap = 0;
         end else begin
            slot.gap = idle_length();
            if ($urandom_range(0, 99) < 2) send_calm = $urandom_range(30, 120);
         end
         pending_chars.push_back(slot);
      end
      drain_next = 1'b0;
      line_buf.delete();
   endtask

   task automatic send_text(input string s, input bit eol);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
      send_line(eol);
   endtask

   task automatic put_digits(input int n);
      repeat (n) line_buf.push_back(8'("0" + $urandom_range(0, 9)));
   endtask

   task automatic put_letter();
      int b;
      b = $urandom_range(0, 51);
      line_buf.push_back((b < 26) ? 8'("a" + b) : 8'("A" + b - 26));
   endtask

   task automatic put_identifier(input int tail);
      int r;
      put_letter();
      repeat (tail) begin
         r = $urandom_range(0, 9);
         if (r < 6) put_letter();
         else if (r < 9) put_digits(1);
         else line_buf.push_back("_");
      end
   endtask

   task automatic put_exponent_mark();
      line_buf.push_back($urandom_range(0, 1) ? "e" : "E");
   endtask

   task automatic put_comment(input int body);
      line_buf.push_back("/");
      line_buf.push_back("/");
      repeat (body) line_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------

   initial begin
      string operators;
      int    random_start;
      int    tokens;
      int    r;
      operators = "+*=^()-";

      // Directed lines: every token kind but integer and float, the unfinished
      // number forms, an identifier cut by the letter e, rejected characters at
      // the start state, a space at end of line, and a character that both
      // closes one token and flushes the next at end of line.
      send_text("0.9e-7 Zz_e", 1'b1);
      send_text("1.", 1'b1);
      send_text("4e-", 1'b1);
      send_text("_", 1'b0);
      line_buf.push_back(8'hFF);
      send_line(1'b0);
      send_text(" ", 1'b1);
      send_text("-/=", 1'b1);
      send_text("//", 1'b1);
      line_buf.push_back(8'h00);
      send_line(1'b1);

      // Tokens long enough to saturate the length, one exactly at the cap.
      drain_next = 1'b1;
      put_comment(253);
      send_line(1'b1);
      put_comment(270);
      send_line(1'b1);
      put_digits(260);
      send_text(" ", 1'b0);
      put_identifier(258);
      send_line(1'b1);

      random_start = pending_chars.size();
      drain_next   = 1'b1;
      while (pending_chars.size() - random_start < RANDOM_CHARS) begin
         tokens = $urandom_range(1, 6);
         repeat (tokens) begin
            r = $urandom_range(0, 99);
            if (r < 18) begin
               put_digits($urandom_range(1, 4));
            end else if (r < 28) begin
               put_digits($urandom_range(1, 3));
               line_buf.push_back(".");
               put_digits($urandom_range(1, 3));
            end else if (r < 38) begin
               put_digits($urandom_range(1, 3));
               if ($urandom_range(0, 1)) begin
                  line_buf.push_back(".");
                  put_digits($urandom_range(1, 2));
               end
               put_exponent_mark();
               if ($urandom_range(0, 1)) line_buf.push_back("-");
               put_digits($urandom_range(1, 2));
            end else if (r < 58) begin
               put_identifier($urandom_range(0, 5));
            end else if (r < 70) begin
               line_buf.push_back(8'(operators[$urandom_range(0, operators.len() - 1)]));
            end else if (r < 75) begin
               line_buf.push_back("/");
            end else if (r < 81) begin
               // Number cut short after the dot, the e or the minus.
               put_digits($urandom_range(1, 2));
               case ($urandom_range(0, 2))
                  0: line_buf.push_back(".");
                  1: put_exponent_mark();
                  default: begin
                     put_exponent_mark();
                     line_buf.push_back("-");
                  end
               endcase
            end else if (r < 89) begin
               line_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
               repeat ($urandom_range(1, 3)) line_buf.push_back(" ");
            end
            if ($urandom_range(0, 99) < 55) line_buf.push_back(" ");
         end
         if ($urandom_range(0, 99) < 15) put_comment($urandom_range(0, 20));
         send_line($urandom_range(0, 99) < 90);
         if ($urandom_range(0, 99) < 3) drain_next = 1'b1;
      end
      send_text(" ", 1'b1);

      @(posedge clock);
      while (reset || pending_chars.size() != 0 || req_valid) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   // The payload only changes when no transaction is held by a stall. A
   // character flagged for draining waits until every token is out.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         lex_state = S_START;
         lex_len   = '0;
         idle_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_tokens(req_data);
            pending_chars.delete(0);
            if (pending_chars.size() != 0) idle_left = pending_chars[0].gap;
         end
         if (!req_valid || !req_stall) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (pending_chars.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_chars[0].drain_first && expected_tokens.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= pending_chars[0].data;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor and stall generator
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: unexpected token kind %0d length %0d last %0b", $realtime,
                           rsp_data.token_kind, rsp_data.token_length,
                           rsp_data.last_in_run);
               end
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_data.token_kind !== want.token_kind ||
                   rsp_data.token_length !== want.token_length ||
                   rsp_data.last_in_run !== want.last_in_run) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("%0t: token mismatch: expected kind %0d length %0d last %0b,",
                              $realtime, want.token_kind, want.token_length,
                              want.last_in_run);
                     $display("   got kind %0d length %0d last %0b",
                              rsp_data.token_kind, rsp_data.token_length,
                              rsp_data.last_in_run);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (recv_calm > 0) begin
               recv_calm--;
            end else if ($urandom_range(0, 99) < 2) begin
               recv_calm = $urandom_range(30, 150);
            end else begin
               stall_left = idle_length();
            end
         end
      end
   end

   // Guards against a hung handshake or a token that never arrives.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

`default_nettype wire
